>>> rtl/ucd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared types, constants and decode helpers for the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package ucd_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   // bits gathered before the final continuation byte: 3 + 6 + 6
   localparam int PART_W  = 15;
   localparam int CNT_W   = 2;
   localparam int SLOT_W  = 2;

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] SPACE_CP       = 21'h000020;
   localparam logic [CP_W-1:0] TAB_CP         = 21'h000009;
   localparam logic [CP_W-1:0] VTAB_CP        = 21'h00000B;
   localparam logic [CP_W-1:0] FORM_FEED_CP   = 21'h00000C;
   localparam logic [CP_W-1:0] CR_CP          = 21'h00000D;

   localparam logic [1:0] CONT_TAG = 2'b10;

   // one result item
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            last_of_run;
   } res_type;

   // outcome of decoding a byte as a lead
   typedef struct packed {
      logic              emit;
      res_type           res;
      logic [CNT_W-1:0]  cnt;
      logic [PART_W-1:0] part;
   } lead_type;

   // results of one decode step, handed to the result queue
   typedef struct packed {
      logic [SLOT_W-1:0] push_n;
      res_type           r0;
      res_type           r1;
   } step_type;

   // map tab, vertical tab, form feed and carriage return to space
   function automatic logic [CP_W-1:0] blank_controls(input logic [CP_W-1:0] v);
      logic [CP_W-1:0] r;
      r = v;
      if (v inside {TAB_CP, VTAB_CP, FORM_FEED_CP, CR_CP}) begin
         r = SPACE_CP;
      end
      return r;
   endfunction

   function automatic res_type make_res(input logic [CP_W-1:0] cp, input logic bad);
      res_type r;
      r.code_point  = cp;
      r.malformed   = bad;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // decode a byte seen while no sequence is pending
   function automatic lead_type lead_decode(input logic [BYTE_W-1:0] b);
      lead_type l;
      l.emit = 1'b0;
      l.res  = make_res(REPLACEMENT_CP, 1'b1);
      l.cnt  = '0;
      l.part = '0;
      if (b == '0) begin
         l.emit = 1'b0;
      end else if (b[7] == 1'b0) begin
         l.emit = 1'b1;
         l.res  = make_res(blank_controls({13'd0, b}), 1'b0);
      end else if (b[7:5] == 3'b110) begin
         l.cnt  = 2'd1;
         l.part = {10'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         l.cnt  = 2'd2;
         l.part = {11'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         l.cnt  = 2'd3;
         l.part = {12'd0, b[2:0]};
      end else begin
         l.emit = 1'b1;
      end
      return l;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ucd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_req_if / ucd_rsp_if
// Valid/ready channels for text bytes in and decoded code points out.
// ----------------------------------------------------------------------------
interface ucd_req_if import ucd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface ucd_rsp_if import ucd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            malformed;
   logic            last_of_run;

   modport source (output valid, output code_point, output malformed,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input malformed,
                   input last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/ucd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_decode
// Sequence state and single-pass decode of the registered byte into zero,
// one or two results.
// ----------------------------------------------------------------------------
module ucd_decode import ucd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic [SLOT_W-1:0] space,
   output logic              fire,
   output step_type          step
);

   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic [PART_W-1:0] part_ff, part_in;
   lead_type          lead;
   logic              is_cont;
   logic [SLOT_W-1:0] n;
   res_type           r0;
   res_type           r1;

   // work out the results and the next state for the held byte
   always_comb begin
      lead    = lead_decode(in_byte);
      is_cont = (in_byte[7:6] == CONT_TAG);
      n       = '0;
      r0      = lead.res;
      r1      = lead.res;
      cnt_in  = lead.cnt;
      part_in = lead.part;
      if (cnt_ff != '0) begin
         if (is_cont) begin
            cnt_in = cnt_ff - 2'd1;
            if (cnt_ff == 2'd1) begin
               n       = 2'd1;
               r0      = make_res(blank_controls({part_ff, in_byte[5:0]}), 1'b0);
               part_in = '0;
            end else begin
               part_in = {part_ff[PART_W-7:0], in_byte[5:0]};
            end
         end else begin
            // broken sequence: replace, then decode the byte again as a lead
            r0 = make_res(REPLACEMENT_CP, 1'b1);
            n  = lead.emit ? 2'd2 : 2'd1;
         end
      end else begin
         n = {1'b0, lead.emit};
      end
      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = 1'b1;
   end

   // take the byte only when the queue has room for all its results
   assign fire        = in_valid && (n <= space);
   assign step.push_n = fire ? n : '0;
   assign step.r0     = r0;
   assign step.r1     = r1;

   // advance the sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         part_ff <= '0;
      end else if (fire) begin
         cnt_ff  <= cnt_in;
         part_ff <= part_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/ucd_rsp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucd_rsp_queue
// Two-entry result register that takes up to two items per cycle and hands
// out one per cycle while the result port is ready.
// ----------------------------------------------------------------------------
module ucd_rsp_queue import ucd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step,
   output logic [SLOT_W-1:0] space,
   ucd_rsp_if.source         rsp_if
);

   res_type           ent_ff [2];
   logic              head_ff, head_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic              pop;
   logic              wr0;
   logic              wr1;
   res_type           head_ent;

   assign pop      = (count_ff != '0) && rsp_if.ready;
   assign space    = SLOT_W'(2'd2 - count_ff + {1'b0, pop});
   assign wr0      = head_ff ^ count_ff[0];
   assign wr1      = ~wr0;
   assign head_in  = head_ff ^ pop;
   assign count_in = SLOT_W'(count_ff + step.push_n - {1'b0, pop});

   // drive the oldest item
   assign head_ent           = ent_ff[head_ff];
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.code_point  = head_ent.code_point;
   assign rsp_if.malformed   = head_ent.malformed;
   assign rsp_if.last_of_run = head_ent.last_of_run;

   // hold pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // write new items behind the queued ones
   always_ff @(posedge clock) begin
      if (step.push_n != '0) begin
         ent_ff[wr0] <= step.r0;
      end
      if (step.push_n == 2'd2) begin
         ent_ff[wr1] <= step.r1;
      end
   end

endmodule
`default_nettype wire

>>> rtl/utf8_codepoint_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_core
// UTF-8 byte stream in, decoded code points out.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the byte register, is decoded combinationally
// and its results are written into the result queue that drives the port.
// Throughput: one byte per cycle while the queue has room; a byte giving two
// results can stall the next byte, as the single-item port drains the queue.
// Reset: synchronous, active high; clears the byte register's valid flag, the
// sequence state and the result queue's pointers.
module utf8_codepoint_decoder_core import ucd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ucd_req_if.sink   req_if,
   ucd_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              fire;
   logic [SLOT_W-1:0] space;
   step_type          step;
   logic              take;

   // refill the byte register whenever it empties or is consumed
   assign req_if.ready = !in_valid_ff || fire;
   assign take         = req_if.valid && req_if.ready;
   assign in_valid_in  = take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_if.text_byte;
      end
   end

   ucd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .space    (space),
      .fire     (fire),
      .step     (step)
   );

   ucd_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .space  (space),
      .rsp_if (rsp_if)
   );

endmodule
`default_nettype wire
